// ===== rtl/wc3_pkg.sv =====
// Shared types, register codes and constants for the 3x3 window convolution.
package wc3_pkg;

	// Pixel layout
	localparam int PIX_W  = 8;
	localparam int NUM_CH = 4;
	localparam int KSIZE  = 3;

	localparam int CH_GRAY  = 0;
	localparam int CH_RED   = 1;
	localparam int CH_GREEN = 2;
	localparam int CH_BLUE  = 3;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;
	localparam int DIM_W     = 11;
	localparam int KROW_W    = KSIZE * PIX_W;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// Default geometry limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Window row / column positions
	localparam int ROW_TOP = 0;
	localparam int ROW_MID = 1;
	localparam int ROW_BOT = 2;
	localparam int COL_LFT = 0;
	localparam int COL_MID = 1;
	localparam int COL_RGT = 2;

	typedef struct packed {
		logic [PIX_W-1:0]              alpha;
		logic [NUM_CH-1:0][PIX_W-1:0]  color;
	} pixel_t;

	// One window column, indexed by window row
	typedef pixel_t [KSIZE-1:0] column_t;
	// Full window, indexed by window column
	typedef column_t [KSIZE-1:0] window_t;

	// Line buffer entry: pixel one row up and pixel two rows up
	typedef struct packed {
		pixel_t near;
		pixel_t far;
	} line_pair_t;

	// Which neighbors of the center lie inside the frame
	typedef struct packed {
		logic up;
		logic dn;
		logic lf;
		logic rt;
	} border_t;

	// Per-transaction control from the raster counter
	typedef struct packed {
		logic    emit;
		logic    last;
		logic    zero_fill;
		border_t border;
	} raster_ctl_t;

endpackage

// ===== rtl/wc3_if.sv =====
// Stream interfaces for incoming pixels and outgoing results.
interface wc3_pix_if import wc3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [PIX_W-1:0] in_gray;
	logic [PIX_W-1:0] in_red;
	logic [PIX_W-1:0] in_green;
	logic [PIX_W-1:0] in_blue;
	logic [PIX_W-1:0] in_alpha;

	modport source (
		output valid, mode, in_gray, in_red, in_green, in_blue, in_alpha,
		input  ready
	);
	modport sink (
		input  valid, mode, in_gray, in_red, in_green, in_blue, in_alpha,
		output ready
	);
endinterface

interface wc3_res_if import wc3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_gray;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic [PIX_W-1:0] out_alpha;
	logic             frame_end;

	modport source (
		output valid, out_gray, out_red, out_green, out_blue, out_alpha, frame_end,
		input  ready
	);
	modport sink (
		input  valid, out_gray, out_red, out_green, out_blue, out_alpha, frame_end,
		output ready
	);
endinterface

// ===== rtl/wc3_raster.sv =====
// Raster position counter and per-transaction window control.
module wc3_raster import wc3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 2),
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          restart,
	input  logic          mode,
	input  logic [WW-1:0] width,
	input  logic [HW-1:0] height,
	output logic [CW-1:0] col,
	output raster_ctl_t   ctl
);

	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic          col_nz;
	logic [WW-1:0] col_inc;
	logic          wrap;

	// Decode the window position of the current transaction
	always_comb begin
		col_nz            = (col_q != '0);
		ctl.emit          = (row_q >= HW'(2)) || ((row_q == HW'(1)) && col_nz);
		ctl.last          = !col_nz && (row_q == height + HW'(1));
		ctl.zero_fill     = mode || (row_q >= height);
		ctl.border.up     = col_nz ? (row_q >= HW'(2)) : (row_q >= HW'(3));
		ctl.border.dn     = col_nz ? (row_q < height) : (row_q <= height);
		ctl.border.lf     = col_nz ? (col_q >= CW'(2)) : (width != WW'(1));
		ctl.border.rt     = col_nz;
		col_inc           = WW'(col_q) + WW'(1);
		wrap              = (col_inc == width);
	end

	assign col = col_q;

	// Advance the raster position; drop back to frame start on restart or frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (ctl.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + HW'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < width)
		else $error("column counter beyond frame width");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.last && !restart |=> (col_q == '0) && (row_q == '0))
		else $error("counters not cleared after frame end");

endmodule

// ===== rtl/wc3_line_buffer.sv =====
// Two-row line store: one write and one registered read per cycle.
module wc3_line_buffer import wc3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [CW-1:0] raddr,
	input  logic          we,
	input  logic [CW-1:0] waddr,
	input  line_pair_t    wdata,
	output line_pair_t    rdata
);

	line_pair_t mem [MAX_WIDTH];
	line_pair_t rdata_q;

	// Store the newest column pair
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read the column pair; forward a same-address write (one-pixel rows)
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/wc3_conv.sv =====
// 3x3 weighted sum per color channel with border masking and clamp to a byte.
module wc3_conv import wc3_pkg::*; (
	input  window_t                         win,
	input  border_t                         border,
	input  logic [KSIZE-1:0][KROW_W-1:0]    kernel,
	output logic [NUM_CH-1:0][PIX_W-1:0]    color
);

	localparam int PROD_W  = 2 * PIX_W + 1;
	localparam int SUM_W   = PROD_W + 4;
	localparam int PIX_MAX = (1 << PIX_W) - 1;

	logic                    tap_ok [KSIZE][KSIZE];
	logic [PIX_W-1:0]        tap_px [NUM_CH][KSIZE][KSIZE];
	logic signed [PROD_W-1:0] prod  [NUM_CH][KSIZE][KSIZE];
	logic signed [SUM_W-1:0]  acc   [NUM_CH];

	// Mask neighbors outside the frame
	always_comb begin
		for (int r = 0; r < KSIZE; r++) begin
			for (int c = 0; c < KSIZE; c++) begin
				tap_ok[r][c] = ((r != ROW_TOP) || border.up) && ((r != ROW_BOT) || border.dn)
					&& ((c != COL_LFT) || border.lf) && ((c != COL_RGT) || border.rt);
			end
		end
	end

	// Weight each tap by its signed coefficient
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int r = 0; r < KSIZE; r++) begin
				for (int c = 0; c < KSIZE; c++) begin
					tap_px[ch][r][c] = tap_ok[r][c] ? win[c][r].color[ch] : '0;
					prod[ch][r][c]   = $signed({1'b0, tap_px[ch][r][c]})
						* $signed(kernel[r][PIX_W*c +: PIX_W]);
				end
			end
		end
	end

	// Sum the taps and clamp to the pixel range
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			acc[ch] = '0;
			for (int r = 0; r < KSIZE; r++) begin
				for (int c = 0; c < KSIZE; c++) begin
					acc[ch] = acc[ch] + SUM_W'(prod[ch][r][c]);
				end
			end
			if (acc[ch] < 0) begin
				color[ch] = '0;
			end else if (acc[ch] > PIX_MAX) begin
				color[ch] = '1;
			end else begin
				color[ch] = acc[ch][PIX_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/window_convolution_3x3.sv =====
// Top level of the 3x3 window convolution with zero padding.
//
// Takes one pixel transaction per clock and gives one result per clock unless
// results stall. The result for a pixel leaves width+1 transactions after that
// pixel arrives, so a frame is closed by width+1 flush transactions; through
// the block a transaction takes two register stages (input/line-buffer read,
// then the result register), and throughput is set by the single line buffer
// (MAX_WIDTH entries of two pixels, one read and one write per cycle) and the
// multiply-add of the nine taps. No clearing pass is needed after reset: every
// neighbor inside the frame is written before it is read. Write frame_width or
// frame_height only while idle; either write restarts the frame.
module window_convolution_3x3 import wc3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	wc3_pix_if.sink              pixels,
	wc3_res_if.source            results
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 2);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WIDTH_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
	localparam int HEIGHT_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

	logic [WW-1:0]                   width_q;
	logic [HW-1:0]                   height_q;
	logic [KSIZE-1:0][KROW_W-1:0]    kernel_q;
	logic [DIM_W-1:0]                cfg_dim;
	logic [WW-1:0]                   width_d;
	logic [HW-1:0]                   height_d;
	logic                            restart;

	logic                            accept;
	logic [CW-1:0]                   rd_col;
	raster_ctl_t                     ctl_d;

	logic                            s1_valid_s1;
	raster_ctl_t                     ctl_s1;
	logic [CW-1:0]                   col_s1;
	pixel_t                          px_s1;
	logic                            s1_adv;

	line_pair_t                      lb_rdata;
	line_pair_t                      lb_wdata;
	column_t                         win_lft_q;
	column_t                         win_mid_q;
	column_t                         win_rgt;
	window_t                         win;
	logic [NUM_CH-1:0][PIX_W-1:0]    conv_color;

	logic                            out_valid_q;
	logic [NUM_CH-1:0][PIX_W-1:0]    out_color_q;
	logic [PIX_W-1:0]                out_alpha_q;
	logic                            frame_end_q;

	// Clamp geometry writes into the supported range
	always_comb begin
		cfg_dim = cfg_wdata[DIM_W-1:0];
		if (cfg_dim == '0) begin
			width_d  = WW'(1);
			height_d = HW'(1);
		end else begin
			width_d  = (32'(cfg_dim) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_dim);
			height_d = (32'(cfg_dim) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_dim);
		end
		restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WIDTH_RST);
			height_q <= HW'(HEIGHT_RST);
			kernel_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					width_q <= width_d;
				end
				REG_FRAME_HEIGHT: begin
					height_q <= height_d;
				end
				REG_KERNEL_TOP: begin
					kernel_q[ROW_TOP] <= cfg_wdata[KROW_W-1:0];
				end
				REG_KERNEL_MIDDLE: begin
					kernel_q[ROW_MID] <= cfg_wdata[KROW_W-1:0];
				end
				REG_KERNEL_BOTTOM: begin
					kernel_q[ROW_BOT] <= cfg_wdata[KROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Handshake: stage 1 frees when its transaction moves on or needs no result slot
	assign s1_adv        = s1_valid_s1 && (!ctl_s1.emit || !out_valid_q || results.ready);
	assign pixels.ready  = !s1_valid_s1 || s1_adv;
	assign accept        = pixels.valid && pixels.ready;

	wc3_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.restart (restart),
		.mode    (pixels.mode),
		.width   (width_q),
		.height  (height_q),
		.col     (rd_col),
		.ctl     (ctl_d)
	);

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload: zero flush items and pixels past the frame
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
			col_s1 <= rd_col;
			if (ctl_d.zero_fill) begin
				px_s1 <= '0;
			end else begin
				px_s1.color[CH_GRAY]  <= pixels.in_gray;
				px_s1.color[CH_RED]   <= pixels.in_red;
				px_s1.color[CH_GREEN] <= pixels.in_green;
				px_s1.color[CH_BLUE]  <= pixels.in_blue;
				px_s1.alpha           <= pixels.in_alpha;
			end
		end
	end

	// Push the newest pixel down one row in the line store
	always_comb begin
		lb_wdata.near = px_s1;
		lb_wdata.far  = lb_rdata.near;
	end

	wc3_line_buffer #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buffer (
		.clk   (clk),
		.rd_en (accept),
		.raddr (rd_col),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (lb_wdata),
		.rdata (lb_rdata)
	);

	// Assemble the window: two stored columns plus the incoming column
	always_comb begin
		win_rgt[ROW_TOP] = lb_rdata.far;
		win_rgt[ROW_MID] = lb_rdata.near;
		win_rgt[ROW_BOT] = px_s1;
		win[COL_LFT]     = win_lft_q;
		win[COL_MID]     = win_mid_q;
		win[COL_RGT]     = win_rgt;
	end

	// Shift the window by one column per transaction
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			win_lft_q <= win_mid_q;
			win_mid_q <= win_rgt;
		end
	end

	wc3_conv u_conv (
		.win    (win),
		.border (ctl_s1.border),
		.kernel (kernel_q),
		.color  (conv_color)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.emit) begin
			out_color_q <= conv_color;
			out_alpha_q <= win_mid_q[ROW_MID].alpha;
			frame_end_q <= ctl_s1.last;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_gray  = out_color_q[CH_GRAY];
	assign results.out_red   = out_color_q[CH_RED];
	assign results.out_green = out_color_q[CH_GREEN];
	assign results.out_blue  = out_color_q[CH_BLUE];
	assign results.out_alpha = out_alpha_q;
	assign results.frame_end = frame_end_q;

	a_lb_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !s1_adv |=> $stable(lb_rdata))
		else $error("line buffer data changed under a stalled transaction");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> s1_valid_s1 && ctl_s1.emit && out_valid_q && !results.ready)
		else $error("input stalled without a blocked result");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && ctl_s1.last |-> ctl_s1.emit)
		else $error("frame end on a transaction without a result");

endmodule

// ===== test/window_convolution_3x3_tb.sv =====
// Self-checking testbench for the 3x3 window convolution over a raster pixel stream.
`timescale 1ns / 1ps

module window_convolution_3x3_tb;
	import wc3_pkg::*;

	localparam int STORE_DEPTH = 2 * MAX_WIDTH_DEF + 4;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 190;
	localparam int CLAMP_ITEMS = 16;
	localparam int MAX_PRINTED = 100;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Kernel styles for random configuration
	localparam int KSTYLE_RANDOM = 0;
	localparam int KSTYLE_SMALL = 1;
	localparam int KSTYLE_IDENTITY = 2;
	localparam int KSTYLE_EXTREME = 3;

	typedef struct packed {
		logic   mode;
		pixel_t px;
	} pix_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] gray;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] alpha;
		logic             frame_end;
	} conv_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	wc3_pix_if pixels_if ();
	wc3_res_if results_if ();

	window_convolution_3x3 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixels    (pixels_if),
		.results   (results_if)
	);

	// Predictor copy of the block's registers and raster state
	logic [DIM_W-1:0]  frame_w_reg;
	logic [DIM_W-1:0]  frame_h_reg;
	logic [KROW_W-1:0] kernel_reg [KSIZE];
	pixel_t            line_mem [STORE_DEPTH];
	int unsigned       col_cnt;
	int unsigned       row_cnt;
	int unsigned       emit_cnt;

	pix_item_t    pixel_q [$];
	conv_result_t conv_expect_q [$];

	int unsigned pixels_queued;
	int unsigned pixels_taken;
	int unsigned results_seen;
	int unsigned mismatch_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;
	logic        pix_fire;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
		if (v == '0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic void restart_raster();
		col_cnt = 0;
		row_cnt = 0;
		emit_cnt = 0;
	endfunction

	// Store one accepted transaction and compute the result it releases, if any
	function automatic void predict_pixel(input logic mode, input pixel_t px);
		int unsigned w, h, total, pos, q, qr, qc;
		int nr, nc, k;
		int acc [NUM_CH];
		logic [PIX_W-1:0] sat [NUM_CH];
		pixel_t nb;
		conv_result_t r;
		w = eff_dim(frame_w_reg, MAX_WIDTH_DEF);
		h = eff_dim(frame_h_reg, MAX_HEIGHT_DEF);
		total = w * h;
		pos = row_cnt * w + col_cnt;
		if (mode == MODE_PIXEL && pos < total)
			line_mem[pos % STORE_DEPTH] = px;
		else
			line_mem[pos % STORE_DEPTH] = '0;
		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (pos < w + 1)
			return;

		q = emit_cnt;
		qr = q / w;
		qc = q % w;
		for (int ch = 0; ch < NUM_CH; ch++)
			acc[ch] = 0;
		for (int dr = 0; dr < KSIZE; dr++) begin
			nr = int'(qr) + dr - 1;
			if (nr < 0 || nr >= int'(h))
				continue;
			for (int dc = 0; dc < KSIZE; dc++) begin
				nc = int'(qc) + dc - 1;
				if (nc < 0 || nc >= int'(w))
					continue;
				nb = line_mem[(nr * int'(w) + nc) % STORE_DEPTH];
				k = $signed(kernel_reg[dr][8*dc +: 8]);
				for (int ch = 0; ch < NUM_CH; ch++)
					acc[ch] += int'(nb.color[ch]) * k;
			end
		end
		// clamp each sum to a byte
		for (int ch = 0; ch < NUM_CH; ch++)
			sat[ch] = acc[ch] < 0 ? 8'd0 : (acc[ch] > 255 ? 8'd255 : 8'(acc[ch]));
		r.gray = sat[CH_GRAY];
		r.red = sat[CH_RED];
		r.green = sat[CH_GREEN];
		r.blue = sat[CH_BLUE];
		r.alpha = line_mem[(qr * w + qc) % STORE_DEPTH].alpha;
		r.frame_end = (q + 1 >= total);
		conv_expect_q.push_back(r);
		emit_cnt++;
		if (r.frame_end)
			restart_raster();
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		// keep the log short when everything goes wrong
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t: %s", $time, what);
	endtask

	// Drive pixel transactions from the pending queue
	always @(negedge clk) begin
		pix_item_t next_item;
		if (arst_n && (!pixels_if.valid || pix_fire)) begin
			if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pixel_q.pop_front();
				pixels_if.mode <= next_item.mode;
				pixels_if.in_gray <= next_item.px.color[CH_GRAY];
				pixels_if.in_red <= next_item.px.color[CH_RED];
				pixels_if.in_green <= next_item.px.color[CH_GREEN];
				pixels_if.in_blue <= next_item.px.color[CH_BLUE];
				pixels_if.in_alpha <= next_item.px.alpha;
				pixels_if.valid <= 1'b1;
			end else begin
				pixels_if.valid <= 1'b0;
			end
		end
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		results_if.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Check results against expectations, then predict from accepted pixels
	always @(posedge clk) begin
		conv_result_t got, want;
		pixel_t px;
		if (!arst_n) begin
			pix_fire <= 1'b0;
		end else begin
			pix_fire <= pixels_if.valid && pixels_if.ready;
			if (results_if.valid && results_if.ready) begin
				got = {results_if.out_gray, results_if.out_red, results_if.out_green,
					results_if.out_blue, results_if.out_alpha, results_if.frame_end};
				if (conv_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected: %h",
						results_seen, got));
				end else begin
					want = conv_expect_q.pop_front();
					if (got !== want)
						report_mismatch($sformatf({"result %0d: got gray %h red %h green %h ",
							"blue %h alpha %h end %b, want gray %h red %h green %h blue %h ",
							"alpha %h end %b"}, results_seen, got.gray, got.red, got.green,
							got.blue, got.alpha, got.frame_end, want.gray, want.red,
							want.green, want.blue, want.alpha, want.frame_end));
				end
				results_seen++;
			end
			if (pixels_if.valid && pixels_if.ready) begin
				px.color[CH_GRAY] = pixels_if.in_gray;
				px.color[CH_RED] = pixels_if.in_red;
				px.color[CH_GREEN] = pixels_if.in_green;
				px.color[CH_BLUE] = pixels_if.in_blue;
				px.alpha = pixels_if.in_alpha;
				predict_pixel(pixels_if.mode, px);
				pixels_taken++;
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((pixels_if.valid && pixels_if.ready) || (results_if.valid && results_if.ready)
			|| cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("window_convolution_3x3_tb NOT OK");
			$finish;
		end
	end

	function automatic pixel_t rand_pixel();
		pixel_t p;
		for (int ch = 0; ch < NUM_CH; ch++)
			p.color[ch] = 8'($urandom);
		p.alpha = 8'($urandom);
		return p;
	endfunction

	function automatic pixel_t flat_pixel(input logic [PIX_W-1:0] color, input logic [PIX_W-1:0] alpha);
		pixel_t p;
		for (int ch = 0; ch < NUM_CH; ch++)
			p.color[ch] = color;
		p.alpha = alpha;
		return p;
	endfunction

	function automatic void queue_item(input logic mode, input pixel_t px);
		pixel_q.push_back({mode, px});
		pixels_queued++;
	endfunction

	// One frame of pixels followed by its flush tail; noisy frames break the pattern
	function automatic void queue_frame(input int unsigned w, input int unsigned h,
		input bit noisy);
		int unsigned tail;
		for (int unsigned i = 0; i < w * h; i++) begin
			if (noisy && $urandom_range(31) == 0)
				queue_item(MODE_FLUSH, rand_pixel());
			else
				queue_item(MODE_PIXEL, rand_pixel());
		end
		tail = w + 1;
		if (noisy) begin
			case ($urandom_range(7))
				0: tail = tail - $urandom_range(0, w);
				1: tail = tail + $urandom_range(1, 3);
				default: ;
			endcase
		end
		for (int unsigned i = 0; i < tail; i++) begin
			if (noisy && $urandom_range(7) == 0)
				queue_item(MODE_PIXEL, rand_pixel());
			else
				queue_item(MODE_FLUSH, rand_pixel());
		end
	endfunction

	// Wait until every transaction is taken and every result is back
	task automatic wait_drained();
		while (pixels_taken != pixels_queued || conv_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_FRAME_WIDTH: begin
				frame_w_reg = data[DIM_W-1:0];
				restart_raster();
			end
			REG_FRAME_HEIGHT: begin
				frame_h_reg = data[DIM_W-1:0];
				restart_raster();
			end
			REG_KERNEL_TOP: kernel_reg[ROW_TOP] = data[KROW_W-1:0];
			REG_KERNEL_MIDDLE: kernel_reg[ROW_MID] = data[KROW_W-1:0];
			REG_KERNEL_BOTTOM: kernel_reg[ROW_BOT] = data[KROW_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [KROW_W-1:0] rand_krow(input int style);
		logic [KROW_W-1:0] row;
		for (int c = 0; c < KSIZE; c++) begin
			case (style)
				KSTYLE_RANDOM: row[8*c +: 8] = 8'($urandom);
				KSTYLE_SMALL: row[8*c +: 8] = 8'($urandom_range(6)) - 8'd3;
				KSTYLE_EXTREME: row[8*c +: 8] = $urandom_range(1) ? 8'h80 : 8'h7F;
				default: row[8*c +: 8] = 8'h00;
			endcase
		end
		return row;
	endfunction

	task automatic write_kernel(input int style);
		write_reg(REG_KERNEL_TOP, CFG_DAT_W'(rand_krow(style)));
		if (style == KSTYLE_IDENTITY)
			write_reg(REG_KERNEL_MIDDLE, 24'h000100);
		else
			write_reg(REG_KERNEL_MIDDLE, CFG_DAT_W'(rand_krow(style)));
		write_reg(REG_KERNEL_BOTTOM, CFG_DAT_W'(rand_krow(style)));
	endtask

	initial begin
		int unsigned phase_start;
		int unsigned new_w, new_h;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pixels_if.valid = 1'b0;
		pixels_if.mode = MODE_PIXEL;
		pixels_if.in_gray = '0;
		pixels_if.in_red = '0;
		pixels_if.in_green = '0;
		pixels_if.in_blue = '0;
		pixels_if.in_alpha = '0;
		results_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pixels_queued = 0;
		pixels_taken = 0;
		results_seen = 0;
		mismatch_count = 0;
		quiet_cycles = 0;

		// predictor state after reset
		frame_w_reg = DIM_W'(FRAME_WIDTH_RST);
		frame_h_reg = DIM_W'(FRAME_HEIGHT_RST);
		for (int r = 0; r < KSIZE; r++)
			kernel_reg[r] = '0;
		for (int i = 0; i < STORE_DEPTH; i++)
			line_mem[i] = '0;
		restart_raster();

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: single-pixel frames from zero geometry, saturation both ways
		write_reg(REG_FRAME_WIDTH, 24'h000000);
		write_reg(REG_FRAME_HEIGHT, 24'h000000);
		write_reg(REG_KERNEL_TOP, 24'h808080);
		write_reg(REG_KERNEL_MIDDLE, 24'h807F80);
		write_reg(REG_KERNEL_BOTTOM, 24'h7F7F7F);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		queue_item(MODE_PIXEL, flat_pixel(8'hFF, 8'hFF));
		queue_item(MODE_FLUSH, flat_pixel(8'h00, 8'h00));
		queue_item(MODE_FLUSH, flat_pixel(8'hFF, 8'hFF));
		queue_item(MODE_PIXEL, flat_pixel(8'h01, 8'h00));
		queue_item(MODE_FLUSH, rand_pixel());
		queue_item(MODE_FLUSH, rand_pixel());
		// flush in the pixel slot, then a late pixel in the flush tail
		queue_item(MODE_FLUSH, flat_pixel(8'hFF, 8'hFF));
		queue_item(MODE_PIXEL, flat_pixel(8'hFF, 8'hFF));
		queue_item(MODE_FLUSH, rand_pixel());
		wait_drained();
		write_reg(REG_KERNEL_MIDDLE, 24'h008000);
		queue_item(MODE_PIXEL, flat_pixel(8'hFF, 8'h5A));
		queue_item(MODE_FLUSH, rand_pixel());
		queue_item(MODE_FLUSH, rand_pixel());
		wait_drained();

		// Directed: 3x2 frame with junk above the width field and a kernel swap mid-frame
		write_reg(REG_FRAME_WIDTH, 24'hFFF803);
		write_reg(REG_FRAME_HEIGHT, 24'h000002);
		write_reg(REG_KERNEL_TOP, 24'h010201);
		write_reg(REG_KERNEL_MIDDLE, 24'h02FC02);
		write_reg(REG_KERNEL_BOTTOM, 24'h010201);
		for (int i = 0; i < 3; i++)
			queue_item(MODE_PIXEL, flat_pixel(i[0] ? 8'h00 : 8'hFF, 8'(i)));
		wait_drained();
		write_reg(REG_KERNEL_MIDDLE, 24'h020402);
		queue_item(MODE_PIXEL, flat_pixel(8'h00, 8'h03));
		queue_item(MODE_FLUSH, flat_pixel(8'hFF, 8'hFF));
		queue_item(MODE_PIXEL, flat_pixel(8'h00, 8'h05));
		queue_item(MODE_FLUSH, rand_pixel());
		queue_item(MODE_PIXEL, rand_pixel());
		queue_item(MODE_FLUSH, rand_pixel());
		queue_item(MODE_FLUSH, rand_pixel());
		wait_drained();

		// Oversized width clamps; a few transactions, then abandon the frame
		write_reg(REG_FRAME_WIDTH, 24'h0007FF);
		write_reg(REG_FRAME_HEIGHT, 24'h000002);
		write_kernel(KSTYLE_SMALL);
		for (int i = 0; i < CLAMP_ITEMS; i++)
			queue_item(MODE_PIXEL, rand_pixel());
		wait_drained();
		// oversized height clamps; one-pixel rows give each result two transactions after its pixel
		write_reg(REG_FRAME_WIDTH, 24'h000001);
		write_reg(REG_FRAME_HEIGHT, 24'h0007FF);
		write_kernel(KSTYLE_SMALL);
		for (int i = 0; i < CLAMP_ITEMS; i++)
			queue_item(MODE_PIXEL, rand_pixel());
		wait_drained();
		// small geometry ahead of the random phases
		write_reg(REG_FRAME_WIDTH, 24'h000004);
		write_reg(REG_FRAME_HEIGHT, 24'h000003);

		// Random frames under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 87; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 87; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			phase_start = pixels_queued;
			while (pixels_queued - phase_start < PHASE_ITEMS) begin
				if (pixels_queued == phase_start || $urandom_range(1) == 1) begin
					wait_drained();
					if ($urandom_range(3) != 0) begin
						new_w = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
						new_h = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 6);
						write_reg(REG_FRAME_WIDTH, CFG_DAT_W'(new_w));
						write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(new_h));
					end
					if (pixels_queued == phase_start || $urandom_range(1) == 1)
						write_kernel($urandom_range(KSTYLE_EXTREME));
				end
				queue_frame(eff_dim(frame_w_reg, MAX_WIDTH_DEF),
					eff_dim(frame_h_reg, MAX_HEIGHT_DEF), 1'b1);
			end
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("window_convolution_3x3_tb OK");
		else
			$display("window_convolution_3x3_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/wc3_pkg.sv
rtl/wc3_if.sv
rtl/wc3_raster.sv
rtl/wc3_line_buffer.sv
rtl/wc3_conv.sv
rtl/window_convolution_3x3.sv
test/window_convolution_3x3_tb.sv
